FILE: hw/rtl/clustered_transposition_table_macros.svh
// Assertion macros for the clustered transposition table checker.
// Standalone header; no dependencies.
`ifndef CLUSTERED_TRANSPOSITION_TABLE_MACROS_SVH
`define CLUSTERED_TRANSPOSITION_TABLE_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define CTT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define CTT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/ctt_pkg.sv
// Shared types and constants for the clustered transposition table.
// No dependencies.
package ctt_pkg;

  localparam int CLUSTERS_DEF  = 4096;
  localparam int WAYS_DEF      = 3;
  localparam int MOVE_BITS_DEF = 16;

  localparam int DEPTH_FIELD_W = 6;
  localparam int GEN_SPAN    = 255;
  localparam int KEY_BITS    = 32;
  localparam int HASH_BITS   = 64;
  localparam int CNT_BITS    = 13;
  localparam int GEN_BITS    = 8;
  localparam int CNT_RESET   = 4096;
  localparam int GEN_RESET   = 1;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 13;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_CLUSTER_COUNT = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SEARCH_GEN    = 2'd1;

  localparam logic CMD_PROBE = 1'b0;
  localparam logic CMD_STORE = 1'b1;

  typedef struct packed {
    logic                  command;
    logic [HASH_BITS-1:0]  hash_key;
    logic signed [15:0]    new_score;
    logic [15:0]           new_move;
    logic [7:0]            new_depth;
    logic [1:0]            new_node_kind;
  } req_t;

  typedef struct packed {
    logic                     hit;
    logic signed [15:0]       found_score;
    logic [15:0]              found_move;
    logic [DEPTH_FIELD_W-1:0] found_depth;
    logic [1:0]               found_node_kind;
    logic                     replaced_occupied;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic accept;
    logic read;
    logic eval;
    logic write;
  } cmd_t;

  typedef struct packed {
    logic req_store;
    logic clear_last;
    logic rsp_busy;
  } status_t;

endpackage

FILE: hw/rtl/clustered_transposition_table.sv
// Clustered transposition table, top level: sequencer plus datapath.
// Depends on ctt_pkg, ctt_ctrl, ctt_datapath, ctt_ram.
//
// Request channel (req_valid/req_stall/req_word): a probe word looks up the
// cluster picked by the hash key and returns one response word; a store word
// writes the slot chosen by the latest probe and returns nothing.
// Response channel (rsp_valid/rsp_stall/rsp_word): hit data, or on a miss
// whether an occupied way was picked for replacement.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 is the
// cluster count, index 1 the search generation; always ready.
// Sequence: a probe reads the way RAMs, then compares and selects and registers
// its response (the index multiply sits in the accepting cycle); a store does
// one RAM write. One word is in flight at a time, set by the sequencer, which
// holds req_stall high until the word is done.
// Reset: the way RAMs are cleared one cluster row per cycle, with req_stall
// high; config writes are taken meanwhile.
// A stalled response holds in the output register; the next request is still
// accepted, and a probe then waits in its last step until the register frees.
module clustered_transposition_table #(
  parameter int CLUSTERS  = ctt_pkg::CLUSTERS_DEF,
  parameter int WAYS      = ctt_pkg::WAYS_DEF,
  parameter int MOVE_BITS = ctt_pkg::MOVE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  ctt_pkg::req_t                      req_word,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output ctt_pkg::rsp_t                      rsp_word,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ctt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [ctt_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  ctt_pkg::cmd_t    cmd;
  ctt_pkg::status_t status;

  assign cfg_ready = 1'b1;

  ctt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  ctt_datapath #(
    .CLUSTERS  (CLUSTERS),
    .WAYS      (WAYS),
    .MOVE_BITS (MOVE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .req_word  (req_word),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

FILE: hw/rtl/ctt_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
module ctt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/ctt_ctrl.sv
// Sequencer for the clustered transposition table: clear pass, probe, store.
// Depends on ctt_pkg.
module ctt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  ctt_pkg::status_t status,
  output ctt_pkg::cmd_t    cmd
);

  ctt_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ctt_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    unique case (state)
      ctt_pkg::ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = ctt_pkg::ST_IDLE;
        end
      end
      ctt_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = status.req_store ? ctt_pkg::ST_WRITE : ctt_pkg::ST_READ;
        end
      end
      ctt_pkg::ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ctt_pkg::ST_EVAL;
      end
      ctt_pkg::ST_EVAL: begin
        if (!status.rsp_busy) begin
          cmd.eval   = 1'b1;
          state_next = ctt_pkg::ST_IDLE;
        end
      end
      ctt_pkg::ST_WRITE: begin
        cmd.write  = 1'b1;
        state_next = ctt_pkg::ST_IDLE;
      end
      default: begin
        state_next = ctt_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

FILE: hw/rtl/ctt_datapath.sv
// Datapath: config registers, cluster index multiply, way RAMs, hit and
// victim selection, pending slot and result register. Depends on ctt_pkg, ctt_ram.
module ctt_datapath #(
  parameter int CLUSTERS  = ctt_pkg::CLUSTERS_DEF,
  parameter int WAYS      = ctt_pkg::WAYS_DEF,
  parameter int MOVE_BITS = ctt_pkg::MOVE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ctt_pkg::cmd_t                        cmd,
  output ctt_pkg::status_t                     status,
  input  ctt_pkg::req_t                        req_word,
  output logic                                 rsp_valid,
  input  logic                                 rsp_stall,
  output ctt_pkg::rsp_t                        rsp_word,
  input  logic                                 cfg_we,
  input  logic [ctt_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [ctt_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int CW = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int NB = ctt_pkg::CNT_BITS;
  localparam int GB = ctt_pkg::GEN_BITS;
  localparam int KB = ctt_pkg::KEY_BITS;
  localparam int HB = ctt_pkg::HASH_BITS;
  localparam int DB = ctt_pkg::DEPTH_FIELD_W;
  localparam int PB = HB + NB;
  // entry: {move, key, score, meta}; meta = {gen, kind, depth}
  localparam int E_SCORE = 16;
  localparam int E_KEY   = 32;
  localparam int E_MOVE  = E_KEY + KB;
  localparam int ENTRY_W = E_MOVE + MOVE_BITS;
  localparam logic [20:0] CLUSTERS_W = 21'(CLUSTERS);
  localparam logic [CW-1:0] LAST_ROW = CW'(CLUSTERS - 1);

  logic [NB-1:0]   cluster_count;
  logic [GB-1:0]   search_generation;
  logic [NB-1:0]   cnt_eff;
  logic [PB-1:0]   prod;
  logic [CW+NB-1:0] hi_ext;
  logic [CW-1:0]   cidx;
  logic [CW-1:0]   clr_addr;
  ctt_pkg::req_t   req_q;
  logic [CW-1:0]   pending_cluster;
  logic [WW-1:0]   pending_way;
  logic            pending_valid;

  logic [MOVE_BITS+15:0] mv_in_ext;
  logic [GB-1:0]         gen_store;
  logic [ENTRY_W-1:0]    store_entry;
  logic [ENTRY_W-1:0]    wdata;
  logic [CW-1:0]         waddr;
  logic [ENTRY_W-1:0]    rd_entry [WAYS];

  logic [7:0]        db     [WAYS];
  logic [GB-1:0]     g      [WAYS];
  logic signed [9:0] age    [WAYS];
  logic              hit_any;
  logic [WW-1:0]     hit_way;
  logic              empty_any;
  logic [WW-1:0]     empty_way;
  logic [WW-1:0]     min_way;
  logic signed [9:0] min_age;
  logic [WW-1:0]     pick_way;
  logic [ENTRY_W-1:0] hit_entry;
  logic [MOVE_BITS+15:0] mv_out_ext;
  ctt_pkg::rsp_t     rsp_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_count     <= NB'(ctt_pkg::CNT_RESET);
      search_generation <= GB'(ctt_pkg::GEN_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        ctt_pkg::CFG_CLUSTER_COUNT: cluster_count     <= cfg_data[NB-1:0];
        ctt_pkg::CFG_SEARCH_GEN:    search_generation <= cfg_data[GB-1:0];
        default: ;
      endcase
    end
  end

  // cluster = (key * count) >> 64, with count clamped to CLUSTERS
  assign cnt_eff = ({8'd0, cluster_count} > CLUSTERS_W) ? CLUSTERS_W[NB-1:0]
                                                         : cluster_count;
  assign prod    = PB'(req_word.hash_key) * PB'(cnt_eff);
  assign hi_ext  = {CW'(0), prod[PB-1:HB]};

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_q <= req_word;
      cidx  <= hi_ext[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= clr_addr + CW'(1);
    end
  end

  assign mv_in_ext = {MOVE_BITS'(0), req_q.new_move};
  assign gen_store = (search_generation == GB'(ctt_pkg::GEN_SPAN)) ? GB'(1)
                                                                  : search_generation + GB'(1);
  assign store_entry = {mv_in_ext[MOVE_BITS-1:0], req_q.hash_key[KB-1:0], req_q.new_score,
                        gen_store, req_q.new_node_kind, req_q.new_depth[DB-1:0]};
  assign wdata = cmd.clear_step ? '0 : store_entry;
  assign waddr = cmd.clear_step ? clr_addr : pending_cluster;

  for (genvar w = 0; w < WAYS; w++) begin : g_way
    logic we;
    assign we = cmd.clear_step ||
                (cmd.write && pending_valid && (pending_way == WW'(w)));
    ctt_ram #(.WIDTH(ENTRY_W), .DEPTH(CLUSTERS)) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (cmd.read),
      .raddr (cidx),
      .rdata (rd_entry[w])
    );
  end

  always_comb begin
    hit_any   = 1'b0;
    hit_way   = '0;
    empty_any = 1'b0;
    empty_way = '0;
    min_way   = '0;
    for (int w = 0; w < WAYS; w++) begin
      db[w]  = rd_entry[w][7:0];
      g[w]   = rd_entry[w][15:8];
      age[w] = (g[w] > search_generation) ? $signed({2'b00, g[w]}) - 10'sd255
                                          : $signed({2'b00, g[w]});
    end
    min_age = age[0];
    for (int w = 0; w < WAYS; w++) begin
      if (!hit_any && (db[w] != 8'd0) &&
          (rd_entry[w][E_KEY +: KB] == req_q.hash_key[KB-1:0])) begin
        hit_any = 1'b1;
        hit_way = WW'(w);
      end
      if (!empty_any && (db[w] == 8'd0)) begin
        empty_any = 1'b1;
        empty_way = WW'(w);
      end
      if (age[w] < min_age) begin
        min_age = age[w];
        min_way = WW'(w);
      end
    end
  end

  assign pick_way   = hit_any ? hit_way : (empty_any ? empty_way : min_way);
  assign hit_entry  = rd_entry[hit_way];
  assign mv_out_ext = {16'd0, hit_entry[E_MOVE +: MOVE_BITS]};

  always_comb begin
    rsp_next = '0;
    if (hit_any) begin
      rsp_next.hit             = 1'b1;
      rsp_next.found_score     = hit_entry[E_SCORE +: 16];
      rsp_next.found_move      = mv_out_ext[15:0];
      rsp_next.found_depth     = hit_entry[DB-1:0];
      rsp_next.found_node_kind = hit_entry[7:6];
    end else begin
      rsp_next.replaced_occupied = !empty_any;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_cluster <= '0;
      pending_way     <= '0;
      pending_valid   <= 1'b0;
    end else if (cmd.eval) begin
      pending_cluster <= cidx;
      pending_way     <= pick_way;
      pending_valid   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.eval) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      rsp_word <= rsp_next;
    end
  end

  assign status.req_store  = (req_word.command == ctt_pkg::CMD_STORE);
  assign status.clear_last = (clr_addr == LAST_ROW);
  assign status.rsp_busy   = rsp_valid && rsp_stall;

endmodule

FILE: hw/rtl/ctt_checker.sv
// Port-level checks for the clustered transposition table, bound to the top.
// Depends on ctt_pkg and clustered_transposition_table_macros.svh.
`include "clustered_transposition_table_macros.svh"

module ctt_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               req_valid,
  input logic                               req_stall,
  input ctt_pkg::req_t                      req_word,
  input logic                               rsp_valid,
  input logic                               rsp_stall,
  input ctt_pkg::rsp_t                      rsp_word,
  input logic                               cfg_valid,
  input logic                               cfg_ready,
  input logic [ctt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input logic [ctt_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  `CTT_ASSERT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word), "stalled response changed")

  `CTT_ASSERT(a_store_silent, clk, rst, req_valid && !req_stall && req_word.command == ctt_pkg::CMD_STORE |=> !$rose(rsp_valid), "store produced a response")

  `CTT_ASSERT(a_hit_clean, clk, rst, rsp_valid && rsp_word.hit |-> !rsp_word.replaced_occupied, "hit flagged replacement")

  `CTT_ASSERT(a_busy_after_accept, clk, rst, req_valid && !req_stall |=> req_stall, "second word accepted while busy")

  `CTT_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !rsp_valid && req_stall, "activity right after reset")

endmodule

bind clustered_transposition_table ctt_checker u_ctt_checker (.*);
